// File: design/rkw_pkg.sv
// Shared types and constants for the recent key window cache.
// No dependencies; imported by the front, back and top level.
package rkw_pkg;

	localparam int FIELD_BYTES = 30;
	localparam int IN_W        = FIELD_BYTES * 8;
	localparam int COST_W      = 8;
	localparam int TOTAL_W     = 32;
	localparam int SIZE_W      = 6;

	localparam logic [COST_W-1:0] HIT_COST_RESET  = 8'd1;
	localparam logic [COST_W-1:0] MISS_COST_RESET = 8'd5;

	typedef struct packed {
		logic [SIZE_W-1:0] cache_size;
		logic [COST_W-1:0] hit_cost;
		logic [COST_W-1:0] miss_cost;
	} cfg_t;

endpackage

// File: design/recent_key_window_cache_unit.sv
// Top level of the recent key window cache: configuration registers, stream ports,
// and the front, queue and back. Depends on rkw_pkg, rkw_front, rkw_queue, rkw_back.
//
// Each name transaction returns one result: hit flag, that access's cost and the
// saturating running total. The back end reads one stored slot per cycle from the
// slot memory's single read port over n slots, where n is cache_size clamped to
// CAPACITY: it takes the key, issues n reads, lets the compare trail the last read,
// then writes back once the result register is free. The front folds and queues
// the next name meanwhile, and the result register lets the back start the next
// scan while a result waits. Writing cache_size clears all slots, the ring pointer
// and the total at once; there is no clearing pass.
module recent_key_window_cache_unit import rkw_pkg::*; #(
	parameter int CAPACITY  = 32,
	parameter int KEY_BYTES = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// key_bytes_0_7 [63:0], key_bytes_8_15 [127:64], key_bytes_16_23 [191:128],
	// key_bytes_24_29 [239:192]
	input  logic [239:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// access_cost [7:0], total_cost [39:8]
	output logic [39:0]   m_tdata,
	// hit [0]
	output logic [0:0]    m_tuser,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	localparam int KEY_W = KEY_BYTES * 8;

	localparam logic [1:0] REG_CACHE_SIZE = 2'd0;
	localparam logic [1:0] REG_HIT_COST   = 2'd1;
	localparam logic [1:0] REG_MISS_COST  = 2'd2;

	cfg_t               cfg_q;
	logic               clear;
	logic               fk_valid;
	logic               fk_ready;
	logic [KEY_W-1:0]   fk_key;
	logic               qk_valid;
	logic               qk_ready;
	logic [KEY_W-1:0]   qk_key;
	logic               res_hit;
	logic [COST_W-1:0]  res_cost;
	logic [TOTAL_W-1:0] res_total;

	assign cfg_ready = 1'b1;
	assign clear     = cfg_valid && (cfg_index == REG_CACHE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cache_size <= '0;
			cfg_q.hit_cost   <= HIT_COST_RESET;
			cfg_q.miss_cost  <= MISS_COST_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CACHE_SIZE: cfg_q.cache_size <= cfg_data[SIZE_W-1:0];
				REG_HIT_COST:   cfg_q.hit_cost   <= cfg_data;
				REG_MISS_COST:  cfg_q.miss_cost  <= cfg_data;
				default: ;
			endcase
		end
	end

	rkw_front #(
		.KEY_BYTES (KEY_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.key_valid (fk_valid),
		.key_ready (fk_ready),
		.key       (fk_key)
	);

	rkw_queue #(
		.W (KEY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fk_valid),
		.push_ready (fk_ready),
		.push_data  (fk_key),
		.pop_valid  (qk_valid),
		.pop_ready  (qk_ready),
		.pop_data   (qk_key)
	);

	rkw_back #(
		.CAPACITY  (CAPACITY),
		.KEY_BYTES (KEY_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.clear     (clear),
		.key_valid (qk_valid),
		.key_ready (qk_ready),
		.key       (qk_key),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_hit   (res_hit),
		.res_cost  (res_cost),
		.res_total (res_total)
	);

	assign m_tdata = {res_total, res_cost};
	assign m_tuser = res_hit;

endmodule

// File: design/rkw_front.sv
// Front end: accepts name transactions, folds case, zeroes bytes after the end.
// Depends on rkw_pkg; feeds the key queue.
module rkw_front import rkw_pkg::*; #(
	parameter int KEY_BYTES = 30
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [IN_W-1:0]        in_data,
	output logic                   key_valid,
	input  logic                   key_ready,
	output logic [KEY_BYTES*8-1:0] key
);

	localparam int KEY_W = KEY_BYTES * 8;

	logic [KEY_BYTES-1:0] zb;
	logic [KEY_BYTES-1:0] pre;
	logic [IN_W-1:0]      raw;
	logic [KEY_W-1:0]     folded;
	logic                 vld_s1;
	logic [KEY_W-1:0]     key_s1;

	// byte 0 of the name sits in the top bits of the first field
	assign raw = {in_data[63:0], in_data[127:64], in_data[191:128], in_data[239:192]};

	for (genvar i = 0; i < KEY_BYTES; i++) begin : g_byte
		logic [7:0] b;
		if (i < FIELD_BYTES) begin : g_in
			assign b = raw[IN_W-1-8*i -: 8];
		end else begin : g_zero
			assign b = 8'd0;
		end
		assign zb[i] = (b == 8'd0);
		if (i == 0) begin : g_first
			assign pre[i] = 1'b0;
		end else begin : g_rest
			assign pre[i] = |zb[i-1:0];
		end
		// fold a..z by clearing bit 5; drop everything after the first zero byte
		assign folded[8*i +: 8] = pre[i] ? 8'd0 :
			((b >= 8'h61 && b <= 8'h7a) ? (b & 8'hdf) : b);
	end

	assign in_ready  = !vld_s1 || key_ready;
	assign key_valid = vld_s1;
	assign key       = key_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_s1 <= folded;
		end
	end

endmodule

// File: design/rkw_queue.sv
// Two-entry queue between the front and the back of the cache.
// No package dependencies.
module rkw_queue #(
	parameter int W = 240
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// File: design/rkw_back.sv
// Back end: scans the slot memory one slot per cycle, writes the key at the ring
// pointer, keeps the running cost and holds the result register. Uses rkw_pkg.
module rkw_back import rkw_pkg::*; #(
	parameter int CAPACITY  = 32,
	parameter int KEY_BYTES = 30
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   clear,
	input  logic                   key_valid,
	output logic                   key_ready,
	input  logic [KEY_BYTES*8-1:0] key,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic                   res_hit,
	output logic [COST_W-1:0]      res_cost,
	output logic [TOTAL_W-1:0]     res_total
);

	localparam int KEY_W = KEY_BYTES * 8;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [KEY_W-1:0]   mem_q [CAPACITY];
	logic [KEY_W-1:0]   rd_data_q;
	logic [CAPACITY-1:0] valid_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [TOTAL_W-1:0] total_q;
	logic [1:0]         state_q;
	logic [KEY_W-1:0]   key_q;
	logic [CNT_W-1:0]   idx_q;
	logic               cmp_vld_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic               hit_q;
	logic               out_vld_q;
	logic               out_hit_q;
	logic [COST_W-1:0]  out_cost_q;
	logic [TOTAL_W-1:0] out_total_q;

	logic [SW-1:0]      size_w;
	logic [CNT_W-1:0]   n;
	logic [IDX_W-1:0]   wr_slot;
	logic [CNT_W-1:0]   nxt;
	logic [IDX_W-1:0]   ptr_next;
	logic               issue;
	logic               match;
	logic               commit;
	logic [COST_W-1:0]  cost;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_next;

	assign size_w  = SW'(cfg.cache_size);
	assign n       = (size_w > SW'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(size_w);
	assign wr_slot = (CNT_W'(ptr_q) < n) ? ptr_q : '0;
	assign nxt     = CNT_W'(wr_slot) + CNT_W'(1);
	assign ptr_next = (nxt >= n) ? '0 : nxt[IDX_W-1:0];

	assign issue  = (state_q == ST_SCAN) && (idx_q < n);
	assign match  = cmp_vld_q && valid_q[cmp_idx_q] && (rd_data_q == key_q);
	assign commit = (state_q == ST_WRITE) && (!out_vld_q || res_ready);

	assign cost       = hit_q ? cfg.hit_cost : cfg.miss_cost;
	assign sum        = {1'b0, total_q} + {{(TOTAL_W + 1 - COST_W){1'b0}}, cost};
	assign total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	assign key_ready = (state_q == ST_IDLE);
	assign res_valid = out_vld_q;
	assign res_hit   = out_hit_q;
	assign res_cost  = out_cost_q;
	assign res_total = out_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			cmp_idx_q <= '0;
			hit_q     <= 1'b0;
			valid_q   <= '0;
			ptr_q     <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving on this edge
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (res_valid && res_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (key_valid) begin
						idx_q     <= '0;
						hit_q     <= 1'b0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// compare uses the registered read data in the cycle after the read
					if (match) hit_q <= 1'b1;
					cmp_vld_q <= issue;
					cmp_idx_q <= idx_q[IDX_W-1:0];
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!cmp_vld_q) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (commit) begin
						if (n != '0) begin
							valid_q[wr_slot] <= 1'b1;
							ptr_q            <= ptr_next;
						end
						total_q   <= total_next;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// cache_size writes must arrive only while idle; the back does not enforce this
			if (clear) begin
				valid_q <= '0;
				ptr_q   <= '0;
				total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && key_ready) begin
			key_q <= key;
		end
		if (issue) begin
			rd_data_q <= mem_q[idx_q[IDX_W-1:0]];
		end
		if (commit && n != '0) begin
			mem_q[wr_slot] <= key_q;
		end
		if (commit) begin
			out_hit_q   <= hit_q;
			out_cost_q  <= cost;
			out_total_q <= total_next;
		end
	end

endmodule
